FILE: design/url_percent_decoder_assert.svh
// Assertion macros shared by the URL percent decoder RTL.
// Depends on nothing; included by the top level.
`ifndef URL_PERCENT_DECODER_ASSERT_SVH
`define URL_PERCENT_DECODER_ASSERT_SVH

// Whenever ante holds at a clock edge, cons must hold at the same edge.
`define UPD_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// cond must never hold at a clock edge outside reset.
`define UPD_ASSERT_NEVER(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error(msg);

`endif

FILE: design/upd_pkg.sv
// Shared types, constants and helper functions of the URL percent decoder.
// Depends on nothing; imported by upd_front, upd_fifo, upd_back and the top level.
package upd_pkg;

  localparam logic [7:0] CHR_PCT   = 8'h25;
  localparam logic [7:0] CHR_PLUS  = 8'h2B;
  localparam logic [7:0] CHR_SPACE = 8'h20;

  localparam int unsigned CAP_W      = 16;
  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_AW    = $clog2(FIFO_DEPTH);

  localparam logic [2:0] APB_AW = 3'd3;
  localparam logic REG_PLUS_MODE = 1'b0;
  localparam logic REG_OUT_CAP   = 1'b1;

  typedef enum logic [2:0] {
    ESC_IDLE  = 3'b001,
    ESC_PCT   = 3'b010,
    ESC_DIGIT = 3'b100
  } esc_phase_e;

  // One classified input byte: up to three literal/decoded bytes, in order b0, b1, b2.
  typedef struct packed {
    logic [7:0] b2;
    logic [7:0] b1;
    logic [7:0] b0;
    logic [1:0] cnt;
    logic       last;
  } upd_entry_t;

  function automatic logic is_hex(input logic [7:0] c);
    return ((c >= 8'h30) && (c <= 8'h39)) ||
           ((c >= 8'h61) && (c <= 8'h66)) ||
           ((c >= 8'h41) && (c <= 8'h46));
  endfunction

  // Only meaningful for a valid hex digit; letters have low nibble 1..6.
  function automatic logic [3:0] hex_val(input logic [7:0] c);
    logic [3:0] v;
    if (c >= 8'h41) begin
      v = c[3:0] + 4'd9;
    end else begin
      v = c[3:0];
    end
    return v;
  endfunction

endpackage

FILE: design/upd_in_if.sv
// Input channel of the URL percent decoder: one encoded byte per beat.
// Depends on nothing.
interface upd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       in_last;

  modport source (output valid, output in_byte, output in_last, input ready);
  modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

FILE: design/upd_out_if.sv
// Output channel of the URL percent decoder: one decoded byte per beat.
// Depends on nothing.
interface upd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       out_last;
  logic       overflow;

  modport source (output valid, output out_byte, output out_last, output overflow,
                  input ready);
  modport sink   (input valid, input out_byte, input out_last, input overflow,
                  output ready);
endinterface

FILE: design/upd_front.sv
// Front end: accepts encoded bytes, tracks the escape sequence and turns each
// byte into a queue entry of zero to three bytes. Depends on upd_pkg, upd_in_if.
module upd_front import upd_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  upd_in_if.sink       in_i,
  input  logic         plus_mode_i,
  input  logic         full_i,
  output logic         push_o,
  output upd_entry_t   entry_o
);

  esc_phase_e phase_q, phase_d;
  logic [7:0] digit_q, digit_d;

  logic [7:0] c;
  logic       last;
  logic       c_hex;
  logic       c_pct;
  logic [7:0] id_byte;
  logic       id_cnt;
  logic       use_idle;
  logic [7:0] pre0, pre1;
  logic [1:0] pre_n;

  assign c     = in_i.in_byte;
  assign last  = in_i.in_last;
  assign c_hex = is_hex(c);
  assign c_pct = (c == CHR_PCT);

  assign in_i.ready = !full_i;
  assign push_o     = in_i.valid && !full_i;

  // Handling of a byte seen with no escape pending.
  always_comb begin
    id_cnt = !c_pct || last;
    if (c_pct) begin
      id_byte = CHR_PCT;
    end else if (plus_mode_i && (c == CHR_PLUS)) begin
      id_byte = CHR_SPACE;
    end else begin
      id_byte = c;
    end
  end

  always_comb begin
    use_idle = 1'b0;
    pre0     = CHR_PCT;
    pre1     = c;
    pre_n    = 2'd0;
    digit_d  = digit_q;
    phase_d  = ESC_IDLE;
    case (phase_q)
      ESC_PCT: begin
        if (c_hex) begin
          if (last) begin
            pre_n = 2'd2;
          end else begin
            digit_d = c;
            phase_d = ESC_DIGIT;
          end
        end else begin
          pre_n    = 2'd1;
          use_idle = 1'b1;
        end
      end
      ESC_DIGIT: begin
        if (c_hex) begin
          pre0  = {hex_val(digit_q), hex_val(c)};
          pre_n = 2'd1;
        end else begin
          pre1     = digit_q;
          pre_n    = 2'd2;
          use_idle = 1'b1;
        end
      end
      default: begin
        use_idle = 1'b1;
      end
    endcase
    if (use_idle && c_pct && !last) begin
      phase_d = ESC_PCT;
    end
    if (last) begin
      phase_d = ESC_IDLE;
      digit_d = 8'h00;
    end
  end

  always_comb begin
    entry_o.b0   = (pre_n == 2'd0) ? id_byte : pre0;
    entry_o.b1   = (pre_n == 2'd1) ? id_byte : pre1;
    entry_o.b2   = id_byte;
    entry_o.cnt  = pre_n + {1'b0, use_idle && id_cnt};
    entry_o.last = last;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= ESC_IDLE;
      digit_q <= 8'h00;
    end else if (push_o) begin
      phase_q <= phase_d;
      digit_q <= digit_d;
    end
  end

endmodule

FILE: design/upd_fifo.sv
// Short entry queue between the front end and the back end.
// Depends on upd_pkg.
module upd_fifo import upd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  upd_entry_t data_i,
  input  logic       pop_i,
  output logic       full_o,
  output logic       valid_o,
  output upd_entry_t data_o
);

  upd_entry_t             mem_q [FIFO_DEPTH];
  logic [FIFO_AW-1:0]     wr_ptr_q, rd_ptr_q;
  logic [FIFO_AW:0]       cnt_q;
  logic                   do_push, do_pop;

  assign full_o  = (cnt_q == FIFO_AW'(0) + (FIFO_AW+1)'(FIFO_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + FIFO_AW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + FIFO_AW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + (FIFO_AW+1)'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - (FIFO_AW+1)'(1);
      end
    end
  end

endmodule

FILE: design/upd_back.sv
// Back end: walks the bytes of each queue entry, applies the capacity check
// and drives the registered output beat. Depends on upd_pkg, upd_out_if.
module upd_back import upd_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  input  upd_entry_t       entry_i,
  input  logic [CAP_W-1:0] out_capacity_i,
  output logic             pop_o,
  output logic             failed_o,
  upd_out_if.source        out_o
);

  logic [1:0]       idx_q, idx_d;
  logic [CAP_W-1:0] count_q, count_d;
  logic             failed_q, failed_d;
  logic             ov_q, ov_d;
  logic [7:0]       byte_q, byte_d;
  logic             last_q, last_d;
  logic             ovf_q, ovf_d;

  logic             can_emit;
  logic             emit;
  logic             at_end;
  logic             cap_hit;
  logic [7:0]       sel_byte;

  assign can_emit = !ov_q || out_o.ready;
  assign at_end   = (2'(idx_q + 2'd1) == entry_i.cnt);
  // The next byte must still leave room for the terminator slot.
  assign cap_hit  = ({1'b0, count_q} + (CAP_W+1)'(1)) >= {1'b0, out_capacity_i};

  always_comb begin
    case (idx_q)
      2'd0:    sel_byte = entry_i.b0;
      2'd1:    sel_byte = entry_i.b1;
      default: sel_byte = entry_i.b2;
    endcase
  end

  always_comb begin
    idx_d    = idx_q;
    count_d  = count_q;
    failed_d = failed_q;
    pop_o    = 1'b0;
    emit     = 1'b0;
    byte_d   = byte_q;
    last_d   = last_q;
    ovf_d    = ovf_q;
    if (valid_i && can_emit) begin
      if (failed_q) begin
        pop_o = 1'b1;
        if (entry_i.last) begin
          emit     = 1'b1;
          byte_d   = 8'h00;
          last_d   = 1'b1;
          ovf_d    = 1'b1;
          count_d  = '0;
          failed_d = 1'b0;
        end
      end else if (entry_i.cnt == 2'd0) begin
        pop_o = 1'b1;
      end else if (cap_hit) begin
        emit   = 1'b1;
        pop_o  = 1'b1;
        idx_d  = 2'd0;
        byte_d = 8'h00;
        last_d = entry_i.last;
        ovf_d  = 1'b1;
        if (entry_i.last) begin
          count_d = '0;
        end else begin
          failed_d = 1'b1;
        end
      end else begin
        emit    = 1'b1;
        byte_d  = sel_byte;
        last_d  = entry_i.last && at_end;
        ovf_d   = 1'b0;
        count_d = count_q + CAP_W'(1);
        if (at_end) begin
          pop_o = 1'b1;
          idx_d = 2'd0;
          if (entry_i.last) begin
            count_d = '0;
          end
        end else begin
          idx_d = idx_q + 2'd1;
        end
      end
    end
    if (emit) begin
      ov_d = 1'b1;
    end else if (out_o.ready) begin
      ov_d = 1'b0;
    end else begin
      ov_d = ov_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q    <= 2'd0;
      count_q  <= '0;
      failed_q <= 1'b0;
      ov_q     <= 1'b0;
    end else begin
      idx_q    <= idx_d;
      count_q  <= count_d;
      failed_q <= failed_d;
      ov_q     <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
    last_q <= last_d;
    ovf_q  <= ovf_d;
  end

  assign failed_o       = failed_q;
  assign out_o.valid    = ov_q;
  assign out_o.out_byte = byte_q;
  assign out_o.out_last = last_q;
  assign out_o.overflow = ovf_q;

endmodule

FILE: design/url_percent_decoder.sv
// An accepted byte is written into the queue; the back end registers its first result beat.
// Throughput: one input byte per cycle while the queue has room; the back end gives one result
// beat per cycle while out_o.ready allows, and a broken escape's two or three beats hold the queue head.
// Reset (rst_ni low, asynchronous) empties the queue, clears the escape and message
// state, and sets plus_mode to 0 and out_capacity to 65535.
//
// Top level of the URL percent decoder. Depends on upd_pkg, upd_in_if, upd_out_if,
// upd_front, upd_fifo, upd_back and url_percent_decoder_assert.svh.
`include "url_percent_decoder_assert.svh"

module url_percent_decoder import upd_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  upd_in_if.sink              in_i,
  upd_out_if.source           out_o,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [APB_AW-1:0]   paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  logic             plus_mode_q;
  logic [CAP_W-1:0] cap_q;
  logic             cfg_wr;

  logic       fifo_full;
  logic       fifo_valid;
  logic       push;
  logic       pop;
  logic       back_failed;
  upd_entry_t entry_in;
  upd_entry_t entry_out;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      plus_mode_q <= 1'b0;
      cap_q       <= '1;
    end else if (cfg_wr) begin
      case (paddr[2])
        REG_PLUS_MODE: plus_mode_q <= pwdata[0];
        REG_OUT_CAP:   cap_q       <= pwdata[CAP_W-1:0];
        default:       ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_PLUS_MODE: prdata = {31'd0, plus_mode_q};
      REG_OUT_CAP:   prdata = {(32-CAP_W)'(0), cap_q};
      default:       prdata = '0;
    endcase
  end

  upd_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .plus_mode_i (plus_mode_q),
    .full_i      (fifo_full),
    .push_o      (push),
    .entry_o     (entry_in)
  );

  upd_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (entry_in),
    .pop_i   (pop),
    .full_o  (fifo_full),
    .valid_o (fifo_valid),
    .data_o  (entry_out)
  );

  upd_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .valid_i        (fifo_valid),
    .entry_i        (entry_out),
    .out_capacity_i (cap_q),
    .pop_o          (pop),
    .failed_o       (back_failed),
    .out_o          (out_o)
  );

  `UPD_ASSERT_NEVER(a_ovf_byte_zero, clk_i, rst_ni, out_o.valid && out_o.overflow && (out_o.out_byte != 8'h00), "overflow beat carries a nonzero byte")
  `UPD_ASSERT_IMPL(a_ovf_marks_failed, clk_i, rst_ni, out_o.valid && out_o.ready && out_o.overflow && !out_o.out_last, back_failed, "mid-message overflow without failed message state")
  `UPD_ASSERT_IMPL(a_beat_from_queue, clk_i, rst_ni, $rose(out_o.valid), $past(fifo_valid), "output beat appeared with an empty queue")

endmodule
